/* hdl/shbk_pkg.sv */
// Package for the string hash bucket core: widths, hash constants and the
// status struct passed from the remainder divider to the sequencer.
// No dependencies.
`default_nettype none

package shbk_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned HASH_W   = 32;
    localparam int unsigned LEN_W    = 31;
    localparam int unsigned DIV_STEPS = HASH_W;
    localparam int unsigned STEP_W   = $clog2(DIV_STEPS + 1);

    localparam logic [HASH_W-1:0] HASH_MULT   = 32'd13;
    localparam logic [HASH_W-1:0] HASH_OFFSET = 32'd97;   // 'a'
    localparam logic [LEN_W-1:0]  LEN_RESET   = 31'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

/* hdl/shbk_hash_acc.sv */
// Running polynomial hash accumulator, hash*13 + byte - 'a' modulo 2^32.
// Depends on shbk_pkg.
`default_nettype none

module shbk_hash_acc (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          update,
    input  wire logic                          clear,
    input  wire logic [shbk_pkg::CHAR_W-1:0]   char_byte,
    output logic      [shbk_pkg::HASH_W-1:0]   hash_next
);

    logic [shbk_pkg::HASH_W-1:0] running_hash_reg;
    logic [shbk_pkg::HASH_W-1:0] running_hash_next;

    assign hash_next = running_hash_reg * shbk_pkg::HASH_MULT
                     + {{(shbk_pkg::HASH_W - shbk_pkg::CHAR_W){1'b0}}, char_byte}
                     - shbk_pkg::HASH_OFFSET;

    always_comb begin
        running_hash_next = running_hash_reg;
        if (clear) begin
            running_hash_next = '0;
        end else if (update) begin
            running_hash_next = hash_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_hash_reg <= '0;
        end else begin
            running_hash_reg <= running_hash_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/shbk_divider.sv */
// Restoring remainder divider, one quotient bit per cycle.
// Depends on shbk_pkg. A zero divisor gives a remainder of zero.
`default_nettype none

module shbk_divider (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [shbk_pkg::HASH_W-1:0]  dividend,
    input  wire logic [shbk_pkg::LEN_W-1:0]   divisor,
    output shbk_pkg::div_status_t             status,
    output logic      [shbk_pkg::LEN_W-1:0]   remainder
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [shbk_pkg::STEP_W-1:0]   count_reg;
    logic [shbk_pkg::HASH_W-1:0]   dvd_reg;
    logic [shbk_pkg::LEN_W-1:0]    divisor_reg;
    logic [shbk_pkg::LEN_W-1:0]    rem_reg;
    logic [shbk_pkg::LEN_W-1:0]    rem_next;
    logic [shbk_pkg::HASH_W-1:0]   partial;
    logic [shbk_pkg::HASH_W-1:0]   divisor_ext;

    assign partial     = {rem_reg, dvd_reg[shbk_pkg::HASH_W-1]};
    assign divisor_ext = {1'b0, divisor_reg};

    // Subtract when the shifted partial remainder covers the divisor
    always_comb begin
        if (partial >= divisor_ext) begin
            rem_next = shbk_pkg::LEN_W'(partial - divisor_ext);
        end else begin
            rem_next = shbk_pkg::LEN_W'(partial);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else if (busy_reg) begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == shbk_pkg::STEP_W'(shbk_pkg::DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg     <= dividend;
            divisor_reg <= divisor;
            rem_reg     <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[shbk_pkg::HASH_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = (divisor_reg == '0) ? '0 : rem_reg;

endmodule

`default_nettype wire

/* hdl/string_hash_bucket_core.sv */
// String hash bucket core: hashes a key one byte per item and gives the
// bucket index (hash modulo table length) after the byte flagged as last.
//
// Input channel s_valid/s_ready carries s_char_byte and s_last_char.
// Result channel m_valid/m_ready carries m_bucket_index, one item per key.
// Configuration channel cfg_valid/cfg_ready writes table_length from
// cfg_data and is always ready. The user must write it only while the core
// is idle; the core itself does not enforce this.
//
// A byte without the last flag is taken into the hash and the next byte
// may follow at once. The last byte starts a restoring divider that
// produces one remainder bit per cycle. s_ready stays low until the
// remainder is loaded as the bucket index and m_valid rises.
// The result sits in an output register; ordinary bytes of the next key
// are taken while it waits. If the receiver stalls, a finished division
// holds until the output register frees up.
// Synchronous active-low reset clears the hash, empties the output
// register and sets table_length to 1.
// Depends on shbk_pkg, shbk_hash_acc and shbk_divider.
`default_nettype none

module string_hash_bucket_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [shbk_pkg::CHAR_W-1:0]   s_char_byte,
    input  wire logic                          s_last_char,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [shbk_pkg::LEN_W-1:0]    m_bucket_index,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [shbk_pkg::LEN_W-1:0]    cfg_data
);

    typedef enum logic {
        ST_IDLE,
        ST_DIVIDE
    } state_t;

    state_t                         state_reg;
    logic                           m_valid_reg;
    logic [shbk_pkg::LEN_W-1:0]     m_bucket_index_reg;
    logic [shbk_pkg::LEN_W-1:0]     table_length_reg;

    logic                           s_accept;
    logic                           div_start;
    logic                           out_free;
    logic                           result_load;
    logic [shbk_pkg::HASH_W-1:0]    hash_next;
    logic [shbk_pkg::LEN_W-1:0]     remainder;
    shbk_pkg::div_status_t          div_status;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign div_start = s_accept && s_last_char;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    // Hold the finished remainder until the output register frees
    assign result_load = (state_reg == ST_DIVIDE) && div_status.done
                      && !div_status.busy && out_free;

    shbk_hash_acc u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update    (s_accept),
        .clear     (div_start),
        .char_byte (s_char_byte),
        .hash_next (hash_next)
    );

    shbk_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (hash_next),
        .divisor   (table_length_reg),
        .status    (div_status),
        .remainder (remainder)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            m_valid_reg        <= 1'b0;
            m_bucket_index_reg <= '0;
            table_length_reg   <= shbk_pkg::LEN_RESET;
        end else begin
            if (cfg_valid) begin
                table_length_reg <= cfg_data;
            end
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (div_start) begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    if (result_load) begin
                        m_bucket_index_reg <= remainder;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_bucket_index = m_bucket_index_reg;

endmodule

`default_nettype wire
